// File: hw/rtl/gtc_pkg.sv
package gtc_pkg;

  // Week, hour and minute lengths in seconds.
  localparam logic [19:0] SECS_PER_WEEK = 20'd604800;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [11:0] SECS_PER_MIN  = 12'd60;

  // Modified Julian day of the GPS epoch and the offset to the date algorithm base.
  localparam logic [18:0] MJD_GPS_EPOCH = 19'd44244;
  localparam logic [21:0] B_OFFSET      = 22'd2401538;
  localparam logic [28:0] C_BIAS        = 29'd12210;
  localparam logic [12:0] YEAR_BIAS     = 13'd4715;
  localparam logic [3:0]  MONTH_FEB     = 4'd2;

  // Reciprocal of 36525 for a 29-bit dividend: exact for every dividend below 2^29.
  localparam int          C_SHIFT = 45;
  localparam logic [63:0] C_RECIP_FULL = ((64'd1 << C_SHIFT) + 64'd36524) / 64'd36525;
  localparam logic [29:0] C_RECIP = C_RECIP_FULL[29:0];

  // Reciprocal of 306001 for a 23-bit dividend, folded with the factor 10000.
  localparam int          E_SHIFT = 42;
  localparam logic [63:0] E_RECIP_FULL = ((64'd1 << E_SHIFT) + 64'd306000) / 64'd306001;
  localparam logic [63:0] E_MUL_FULL = E_RECIP_FULL * 64'd10000;
  localparam logic [37:0] E_MUL = E_MUL_FULL[37:0];

  // Reciprocal of 3600 for a 17-bit dividend.
  localparam int          H_SHIFT = 29;
  localparam logic [63:0] H_RECIP_FULL = ((64'd1 << H_SHIFT) + 64'd3599) / 64'd3600;
  localparam logic [17:0] H_RECIP = H_RECIP_FULL[17:0];

  // Reciprocal of 60 for a 12-bit dividend.
  localparam int          M_SHIFT = 18;
  localparam logic [63:0] M_RECIP_FULL = ((64'd1 << M_SHIFT) + 64'd59) / 64'd60;
  localparam logic [12:0] M_RECIP = M_RECIP_FULL[12:0];

  // Seconds at the start of each day of the week.
  function automatic logic [19:0] day_start(input logic [2:0] idx);
    logic [19:0] r;
    case (idx)
      3'd0:    r = 20'd0;
      3'd1:    r = 20'd86400;
      3'd2:    r = 20'd172800;
      3'd3:    r = 20'd259200;
      3'd4:    r = 20'd345600;
      3'd5:    r = 20'd432000;
      3'd6:    r = 20'd518400;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

  // floor(30.6001 * e) for the month index of the date algorithm.
  function automatic logic [8:0] month_days(input logic [4:0] e);
    logic [8:0] r;
    case (e)
      5'd0:    r = 9'd0;
      5'd1:    r = 9'd30;
      5'd2:    r = 9'd61;
      5'd3:    r = 9'd91;
      5'd4:    r = 9'd122;
      5'd5:    r = 9'd153;
      5'd6:    r = 9'd183;
      5'd7:    r = 9'd214;
      5'd8:    r = 9'd244;
      5'd9:    r = 9'd275;
      5'd10:   r = 9'd306;
      5'd11:   r = 9'd336;
      5'd12:   r = 9'd367;
      5'd13:   r = 9'd397;
      5'd14:   r = 9'd428;
      5'd15:   r = 9'd459;
      5'd16:   r = 9'd489;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/gps_time_to_calendar.sv
// GPS time to calendar converter. Each request carries a GPS week number, whole
// seconds of week and microseconds, and produces one result: the modified Julian day,
// the Gregorian year, month and day, the hour, minute and second, and the microseconds
// passed through unchanged. A seconds-of-week value of 604800 or more gives a result
// with invalid set and every other field zero; microseconds above 999999 are passed
// through and never carry into the seconds. The block is a six-stage pipeline: a
// request is taken in every cycle in which request_stall is low. The depth is set by the
// date path, which has two constant reciprocal multiplications (for the century-scaled
// year count and for the month index), each followed by its own register stage; the
// time-of-day path runs alongside with two further reciprocal multiplications. Empty
// stages close up while the result side stalls, so request_stall only rises once all
// six stages hold a request and the waiting result is not being taken. Results leave in
// request order.
module gps_time_to_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        request_valid,
  output logic        request_stall,
  input  logic [15:0] gps_week,
  input  logic [19:0] seconds_of_week,
  input  logic [19:0] micro_seconds,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [18:0] modified_julian_day,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic [19:0] sub_second,
  output logic        invalid
);

  // Stage valid bits and per-stage advance enables.
  logic [6:1] vld;
  logic [6:1] adv;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    adv[6] = !vld[6] || !result_stall;
    for (int k = 5; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign request_stall = !adv[1];
  assign result_valid  = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= request_valid;
      end
      for (int k = 2; k <= 6; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: split the seconds of week into day of week and seconds of day, and form
  // the modified Julian day.
  logic [2:0]  day_idx;
  logic [19:0] sow_rem;

  always_comb begin
    day_idx = 3'd0;
    for (int k = 1; k <= 6; k++) begin
      if (seconds_of_week >= gtc_pkg::day_start(3'(k))) begin
        day_idx = 3'(k);
      end
    end
    sow_rem = seconds_of_week - gtc_pkg::day_start(day_idx);
  end

  logic [18:0] s1_mjd;
  logic [16:0] s1_rem;
  logic [19:0] s1_usec;
  logic        s1_inv;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_mjd  <= gtc_pkg::MJD_GPS_EPOCH + (19'(gps_week) << 3) - 19'(gps_week)
                 + 19'(day_idx);
      s1_rem  <= sow_rem[16:0];
      s1_usec <= micro_seconds;
      s1_inv  <= seconds_of_week >= gtc_pkg::SECS_PER_WEEK;
    end
  end

  // Stage 2: scaled dividend for the year count; reciprocal product for the hour.
  logic [21:0] s1_b;
  assign s1_b = 22'(s1_mjd) + gtc_pkg::B_OFFSET;

  logic [18:0] s2_mjd;
  logic [21:0] s2_b;
  logic [28:0] s2_x;
  logic [16:0] s2_rem;
  logic [34:0] s2_hprod;
  logic [19:0] s2_usec;
  logic        s2_inv;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_mjd   <= s1_mjd;
      s2_b     <= s1_b;
      s2_x     <= 29'(s1_b) * 29'd100 - gtc_pkg::C_BIAS;
      s2_rem   <= s1_rem;
      s2_hprod <= 35'(s1_rem) * 35'(gtc_pkg::H_RECIP);
      s2_usec  <= s1_usec;
      s2_inv   <= s1_inv;
    end
  end

  // Stage 3: reciprocal product for the year count; hour and seconds within the hour.
  logic [4:0] s2_hour;
  assign s2_hour = 5'(s2_hprod >> gtc_pkg::H_SHIFT);

  logic [18:0] s3_mjd;
  logic [21:0] s3_b;
  logic [58:0] s3_cprod;
  logic [4:0]  s3_hour;
  logic [11:0] s3_hrem;
  logic [19:0] s3_usec;
  logic        s3_inv;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_mjd   <= s2_mjd;
      s3_b     <= s2_b;
      s3_cprod <= 59'(s2_x) * 59'(gtc_pkg::C_RECIP);
      s3_hour  <= s2_hour;
      s3_hrem  <= 12'(s2_rem - 17'(s2_hour) * gtc_pkg::SECS_PER_HOUR);
      s3_usec  <= s2_usec;
      s3_inv   <= s2_inv;
    end
  end

  // Stage 4: year count, days since its start; reciprocal product for the minute.
  logic [12:0] s3_c;
  logic [23:0] s3_d;
  logic [21:0] s3_bd;
  assign s3_c  = 13'(s3_cprod >> gtc_pkg::C_SHIFT);
  assign s3_d  = (24'(s3_c) * 24'd1461) >> 2;
  assign s3_bd = s3_b - 22'(s3_d);

  logic [18:0] s4_mjd;
  logic [12:0] s4_c;
  logic [8:0]  s4_bd;
  logic [4:0]  s4_hour;
  logic [11:0] s4_hrem;
  logic [24:0] s4_mprod;
  logic [19:0] s4_usec;
  logic        s4_inv;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_mjd   <= s3_mjd;
      s4_c     <= s3_c;
      s4_bd    <= s3_bd[8:0];
      s4_hour  <= s3_hour;
      s4_hrem  <= s3_hrem;
      s4_mprod <= 25'(s3_hrem) * 25'(gtc_pkg::M_RECIP);
      s4_usec  <= s3_usec;
      s4_inv   <= s3_inv;
    end
  end

  // Stage 5: reciprocal product for the month index; minute and second.
  logic [5:0] s4_min;
  assign s4_min = 6'(s4_mprod >> gtc_pkg::M_SHIFT);

  logic [18:0] s5_mjd;
  logic [12:0] s5_c;
  logic [8:0]  s5_bd;
  logic [46:0] s5_eprod;
  logic [4:0]  s5_hour;
  logic [5:0]  s5_min;
  logic [5:0]  s5_sec;
  logic [19:0] s5_usec;
  logic        s5_inv;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_mjd   <= s4_mjd;
      s5_c     <= s4_c;
      s5_bd    <= s4_bd;
      s5_eprod <= 47'(s4_bd) * 47'(gtc_pkg::E_MUL);
      s5_hour  <= s4_hour;
      s5_min   <= s4_min;
      s5_sec   <= 6'(s4_hrem - 12'(s4_min) * gtc_pkg::SECS_PER_MIN);
      s5_usec  <= s4_usec;
      s5_inv   <= s4_inv;
    end
  end

  // Stage 6: day, month and year, and zeroing of out-of-range requests.
  logic [4:0]  s5_e;
  logic [3:0]  s5_month;
  logic [4:0]  s5_day;
  logic [12:0] s5_year;

  always_comb begin
    s5_e     = 5'(s5_eprod >> gtc_pkg::E_SHIFT);
    s5_month = (s5_e < 5'd14) ? 4'(s5_e - 5'd1) : 4'(s5_e - 5'd13);
    s5_day   = 5'(s5_bd - gtc_pkg::month_days(s5_e));
    s5_year  = s5_c - gtc_pkg::YEAR_BIAS - 13'(s5_month > gtc_pkg::MONTH_FEB);
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      invalid <= s5_inv;
      if (s5_inv) begin
        modified_julian_day <= '0;
        year                <= '0;
        month               <= '0;
        day                 <= '0;
        hour                <= '0;
        minute              <= '0;
        second              <= '0;
        sub_second          <= '0;
      end else begin
        modified_julian_day <= s5_mjd;
        year                <= s5_year[11:0];
        month               <= s5_month;
        day                 <= s5_day;
        hour                <= s5_hour;
        minute              <= s5_min;
        second              <= s5_sec;
        sub_second          <= s5_usec;
      end
    end
  end

  // An out-of-range request must leave with its modified Julian day, month, day and microseconds cleared.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && invalid |-> modified_julian_day == '0 && month == '0 && day == '0
      && sub_second == '0)
    else $error("invalid result carries non-zero fields");

  // A good request gives a month, hour, minute and second within their ranges and a day of at least one.
  a_fields_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && !invalid |-> month >= 4'd1 && month <= 4'd12 && day >= 5'd1
      && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
    else $error("calendar field out of range");

  // Requests are held back only when every stage is full and the result is stalled.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    request_stall |-> vld == '1 && result_stall)
    else $error("request stalled with room in the pipeline");

endmodule
